>>> rtl/sfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Field widths, register indexes, reject codes and shared types for the
// sphere frustum cull unit.
// ----------------------------------------------------------------------------
package sfc_pkg;

  localparam int unsigned CELL_SIZE_DEF = 16;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned CAM_W   = 21;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned LIM_W   = 31;
  localparam int unsigned OFF_W   = 31;
  localparam int unsigned SLOPE_W = 16;

  localparam int unsigned CAM_REG_W  = 3 * CAM_W;
  localparam int unsigned AXIS_REG_W = 3 * AXIS_W;
  localparam int unsigned LIM_REG_W  = 2 * LIM_W;
  localparam int unsigned CONE_REG_W = OFF_W + SLOPE_W;
  localparam int unsigned CFG_W      = CAM_REG_W;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CAMERA  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VCONE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HCONE   = 3'd6;

  typedef enum logic [1:0] {
    REASON_NONE  = 2'd0,
    REASON_DEPTH = 2'd1,
    REASON_VERT  = 2'd2,
    REASON_HORZ  = 2'd3
  } sfc_reason_e;

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } sfc_dot_ctrl_t;

endpackage

>>> rtl/sfc_dot3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-term dot product
// Multiplies a position vector by a packed Q1.14 axis in one register stage
// and adds the three products in the next, with no rounding.
// ----------------------------------------------------------------------------
module sfc_dot3 import sfc_pkg::*; #(
  parameter int unsigned VW = 27,
  parameter int unsigned SW = VW + AXIS_W + 2
) (
  input  logic                  clk_i,
  input  sfc_dot_ctrl_t         ctrl_i,
  input  logic [2:0][VW-1:0]    vec_i,
  input  logic [AXIS_REG_W-1:0] axis_i,
  output logic signed [SW-1:0]  dot_o
);

  localparam int unsigned PW = VW + AXIS_W;

  logic signed [PW-1:0] prod_d [3];
  logic signed [PW-1:0] prod_q [3];
  logic signed [SW-1:0] dot_d;
  logic signed [SW-1:0] dot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = $signed({{AXIS_W{vec_i[i][VW-1]}}, vec_i[i]}) *
                  $signed({{VW{axis_i[AXIS_W*i+AXIS_W-1]}},
                           axis_i[AXIS_W*i +: AXIS_W]});
    end
    dot_d = $signed({{2{prod_q[0][PW-1]}}, prod_q[0]}) +
            $signed({{2{prod_q[1][PW-1]}}, prod_q[1]}) +
            $signed({{2{prod_q[2][PW-1]}}, prod_q[2]});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.en_sum) begin
      dot_q <= dot_d;
    end
  end

  assign dot_o = dot_q;

endmodule

>>> rtl/sphere_frustum_cull_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere frustum cull unit
// Tests the bounding sphere of one chunk per transaction against the view
// frustum given by the camera registers.
//
// The input channel carries chunk_x/y/z with in_valid_i and in_stall_o; the
// output channel carries visible and reject_reason with out_valid_o and
// out_stall_i. A transaction is taken at a clock edge where valid is high and
// stall is low. Configuration is written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, and must only change while no chunk is in flight.
// The pipeline has five register stages: offset vector, axis products, dot
// sums, depth test with cone products, and the cone compares that load the
// output register. One chunk can be taken in any cycle with in_stall_o low.
// Each stage advances when it is empty or the stage after it advances, so
// gaps close up when the receiver stalls; the input stalls only once all
// five stages hold results. Reset empties the pipeline and clears all
// configuration registers to zero.
// ----------------------------------------------------------------------------
module sphere_frustum_cull_unit import sfc_pkg::*; #(
  parameter int unsigned CELL_SIZE = CELL_SIZE_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [COORD_W-1:0] chunk_x_i,
  input  logic signed [COORD_W-1:0] chunk_y_i,
  input  logic signed [COORD_W-1:0] chunk_z_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     visible_o,
  output logic [1:0]               reject_reason_o
);

  localparam int unsigned CENTER_W = $clog2(CELL_SIZE) + 18;
  localparam int unsigned VW   = ((CENTER_W > CAM_W) ? CENTER_W : CAM_W) + 1;
  localparam int unsigned SW   = VW + AXIS_W + 2;
  localparam int unsigned NW   = LIM_W + 14;
  localparam int unsigned DCW  = ((SW > NW) ? SW : NW) + 1;
  localparam int unsigned MW   = SW + SLOPE_W + 1;
  localparam int unsigned OSW  = OFF_W + 26 + 1;
  localparam int unsigned DW   = ((OSW > MW) ? OSW : MW) + 1;
  localparam int unsigned S30W = SW + 12;
  localparam int unsigned CW   = ((DW > S30W) ? DW : S30W) + 1;

  localparam logic signed [VW-1:0] CELL_SCALE = VW'(CELL_SIZE * 16);
  localparam logic signed [VW-1:0] CELL_HALF  = VW'(CELL_SIZE * 8);

  logic [CAM_REG_W-1:0]  camera_q;
  logic [AXIS_REG_W-1:0] front_q;
  logic [AXIS_REG_W-1:0] up_q;
  logic [AXIS_REG_W-1:0] right_q;
  logic [LIM_REG_W-1:0]  depth_q;
  logic [CONE_REG_W-1:0] vcone_q;
  logic [CONE_REG_W-1:0] hcone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      camera_q <= '0;
      front_q  <= '0;
      up_q     <= '0;
      right_q  <= '0;
      depth_q  <= '0;
      vcone_q  <= '0;
      hcone_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CAMERA: camera_q <= cfg_wdata_i[CAM_REG_W-1:0];
        REG_FRONT:  front_q  <= cfg_wdata_i[AXIS_REG_W-1:0];
        REG_UP:     up_q     <= cfg_wdata_i[AXIS_REG_W-1:0];
        REG_RIGHT:  right_q  <= cfg_wdata_i[AXIS_REG_W-1:0];
        REG_DEPTH:  depth_q  <= cfg_wdata_i[LIM_REG_W-1:0];
        REG_VCONE:  vcone_q  <= cfg_wdata_i[CONE_REG_W-1:0];
        REG_HCONE:  hcone_q  <= cfg_wdata_i[CONE_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic vld1_q, vld2_q, vld3_q, vld4_q, out_vld_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = ~out_vld_q | ~out_stall_i;
  assign rdy4 = ~vld4_q | rdy5;
  assign rdy3 = ~vld3_q | rdy4;
  assign rdy2 = ~vld2_q | rdy3;
  assign rdy1 = ~vld1_q | rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      vld3_q    <= 1'b0;
      vld4_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rdy1) begin
        vld1_q <= in_valid_i;
      end
      if (rdy2) begin
        vld2_q <= vld1_q;
      end
      if (rdy3) begin
        vld3_q <= vld2_q;
      end
      if (rdy4) begin
        vld4_q <= vld3_q;
      end
      if (rdy5) begin
        out_vld_q <= vld4_q;
      end
    end
  end

  // Stage 1: chunk centre minus camera position, 4 fraction bits.
  logic signed [COORD_W-1:0] chunk [3];
  logic [2:0][VW-1:0]        vec_d;
  logic [2:0][VW-1:0]        vec_q;

  always_comb begin
    chunk[0] = chunk_x_i;
    chunk[1] = chunk_y_i;
    chunk[2] = chunk_z_i;
    for (int i = 0; i < 3; i++) begin
      vec_d[i] = $signed({{(VW-COORD_W){chunk[i][COORD_W-1]}}, chunk[i]}) * CELL_SCALE
               + CELL_HALF
               - $signed({{(VW-CAM_W){camera_q[CAM_W*i+CAM_W-1]}},
                          camera_q[CAM_W*i +: CAM_W]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  // Stages 2 and 3: the three dot products.
  sfc_dot_ctrl_t        dot_ctrl;
  logic signed [SW-1:0] sz, sy, sx;

  assign dot_ctrl.en_mul = rdy2 & vld1_q;
  assign dot_ctrl.en_sum = rdy3 & vld2_q;

  sfc_dot3 #(.VW(VW), .SW(SW)) u_dot_front (
    .clk_i  (clk_i),
    .ctrl_i (dot_ctrl),
    .vec_i  (vec_q),
    .axis_i (front_q),
    .dot_o  (sz)
  );

  sfc_dot3 #(.VW(VW), .SW(SW)) u_dot_up (
    .clk_i  (clk_i),
    .ctrl_i (dot_ctrl),
    .vec_i  (vec_q),
    .axis_i (up_q),
    .dot_o  (sy)
  );

  sfc_dot3 #(.VW(VW), .SW(SW)) u_dot_right (
    .clk_i  (clk_i),
    .ctrl_i (dot_ctrl),
    .vec_i  (vec_q),
    .axis_i (right_q),
    .dot_o  (sx)
  );

  // Stage 4: depth test and the depth times slope products.
  logic signed [DCW-1:0] sz_dc, near_dc, far_dc;
  logic                  depth_ok_d, depth_ok_q;
  logic signed [MW-1:0]  sz_m;
  logic signed [MW-1:0]  mv_d, mh_d, mv_q, mh_q;
  logic signed [SW-1:0]  sy_q, sx_q;

  always_comb begin
    sz_dc   = $signed({{(DCW-SW){sz[SW-1]}}, sz});
    near_dc = $signed({{(DCW-NW){depth_q[LIM_W-1]}}, depth_q[LIM_W-1:0], 14'd0});
    far_dc  = $signed({{(DCW-NW){depth_q[LIM_REG_W-1]}},
                       depth_q[LIM_REG_W-1:LIM_W], 14'd0});
    depth_ok_d = (near_dc <= sz_dc) && (sz_dc <= far_dc);
    sz_m = $signed({{(MW-SW){sz[SW-1]}}, sz});
    mv_d = sz_m * $signed({{(MW-SLOPE_W){1'b0}}, vcone_q[CONE_REG_W-1:OFF_W]});
    mh_d = sz_m * $signed({{(MW-SLOPE_W){1'b0}}, hcone_q[CONE_REG_W-1:OFF_W]});
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && vld3_q) begin
      depth_ok_q <= depth_ok_d;
      mv_q       <= mv_d;
      mh_q       <= mh_d;
      sy_q       <= sy;
      sx_q       <= sx;
    end
  end

  // Stage 5: cone compares with 30 fraction bits and the reject code.
  logic signed [CW-1:0] dist_v, dist_h, s30_v, s30_h;
  logic                 vert_ok, horz_ok;
  sfc_reason_e          reason_d, reason_q;

  always_comb begin
    dist_v = $signed({{(CW-OFF_W-26){1'b0}}, vcone_q[OFF_W-1:0], 26'd0})
           + $signed({{(CW-MW){mv_q[MW-1]}}, mv_q});
    dist_h = $signed({{(CW-OFF_W-26){1'b0}}, hcone_q[OFF_W-1:0], 26'd0})
           + $signed({{(CW-MW){mh_q[MW-1]}}, mh_q});
    s30_v  = $signed({{(CW-S30W){sy_q[SW-1]}}, sy_q, 12'd0});
    s30_h  = $signed({{(CW-S30W){sx_q[SW-1]}}, sx_q, 12'd0});
    vert_ok = (-dist_v <= s30_v) && (s30_v <= dist_v);
    horz_ok = (-dist_h <= s30_h) && (s30_h <= dist_h);
    priority if (!depth_ok_q) begin
      reason_d = REASON_DEPTH;
    end else if (!vert_ok) begin
      reason_d = REASON_VERT;
    end else if (!horz_ok) begin
      reason_d = REASON_HORZ;
    end else begin
      reason_d = REASON_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5 && vld4_q) begin
      reason_q <= reason_d;
    end
  end

  assign in_stall_o      = ~rdy1;
  assign out_valid_o     = out_vld_q;
  assign visible_o       = (reason_q == REASON_NONE);
  assign reject_reason_o = reason_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld1_q && vld2_q && vld3_q && vld4_q && out_vld_q))
    else $error("input stalled while the pipeline has a free stage");

  a_visible_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (visible_o == (reject_reason_o == REASON_NONE)))
    else $error("visible flag disagrees with reject reason");

  a_stage4_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld4_q && out_vld_q && out_stall_i) |=> (vld4_q && $stable(mv_q) && $stable(mh_q)))
    else $error("stage 4 lost or changed its transaction during a stall");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld4_q && !out_stall_i) |=> out_vld_q)
    else $error("stage 4 transaction did not reach the output register");

endmodule
